// ----- src/pcal_pkg.sv -----
// Shared types and constants for the priority circle area lookup.
package pcal_pkg;

  localparam int unsigned CoordW = 24;
  localparam int unsigned RadW   = 23;
  localparam int unsigned AreaW  = 12;
  localparam int unsigned PrioW  = 16;
  localparam int unsigned CountW = 7;
  localparam int unsigned HgtW   = 23;
  localparam int unsigned RatioW = 17;
  localparam int unsigned D2W    = 50;
  localparam int unsigned R2W    = 46;
  localparam int unsigned EntryW = 3 * CoordW + RadW + AreaW + PrioW;

  localparam logic [1:0] CfgCount = 2'd0;
  localparam logic [1:0] CfgAbove = 2'd1;
  localparam logic [1:0] CfgBelow = 2'd2;

  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic [RadW-1:0]          r;
    logic [AreaW-1:0]         area;
    logic signed [PrioW-1:0]  prio;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic start;  // clear winner, latch query point
    logic test;   // evaluate entry on read data
    logic acc;    // fold stage-2 result into winner
    logic sq_init;
    logic sq_step;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sq_done;
  } dp_sts_t;

endpackage

// ----- src/pcal_ram.sv -----
// Generic single-port-write, registered-read RAM.
module pcal_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- src/pcal_dp.sv -----
// Datapath: entry test pipeline, winner register, iterative ratio unit.
module pcal_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pcal_pkg::dp_cmd_t                  cmd_i,
  output pcal_pkg::dp_sts_t                  sts_o,
  input  pcal_pkg::entry_t                   ent_i,
  input  logic signed [pcal_pkg::CoordW-1:0] px_i,
  input  logic signed [pcal_pkg::CoordW-1:0] py_i,
  input  logic signed [pcal_pkg::CoordW-1:0] pz_i,
  input  logic [pcal_pkg::HgtW-1:0]          above_i,
  input  logic [pcal_pkg::HgtW-1:0]          below_i,
  output logic                               hit_o,
  output logic [pcal_pkg::AreaW-1:0]         area_o,
  output logic signed [pcal_pkg::PrioW-1:0]  prio_o,
  output logic [pcal_pkg::RatioW-1:0]        ratio_o
);
  import pcal_pkg::*;

  localparam int unsigned SqW = R2W + RatioW + 3;

  logic signed [CoordW-1:0] px_q, py_q, pz_q;
  logic signed [CoordW+1:0] top_q, bot_q;

  // stage 1: differences and window
  logic signed [CoordW:0] dx_d, dz_d;
  logic signed [CoordW:0] dx_q, dz_q;
  logic                   inw_q;
  logic [RadW-1:0]        r_q;
  logic [AreaW-1:0]       a1_q;
  logic signed [PrioW-1:0] p1_q;
  logic signed [CoordW+1:0] cy;

  // stage 2: squares
  logic [D2W-1:0]  d2_q;
  logic [R2W-1:0]  r2_q;
  logic            inw2_q;
  logic [AreaW-1:0] a2_q;
  logic signed [PrioW-1:0] p2_q;
  logic [2*CoordW+1:0] sx, sz;

  // winner
  logic            hit_q;
  logic [AreaW-1:0] area_q;
  logic signed [PrioW-1:0] prio_q;
  logic [D2W-1:0]  bd2_q;
  logic [R2W-1:0]  br2_q;

  // ratio unit
  logic [4:0]          bit_q;
  logic                sq_done_q;
  logic [RatioW-1:0]   q_q;
  logic [SqW-1:0]      rem_q, mr_q;
  logic [1:0]          pair;
  logic [SqW-1:0]      rem_sh, trial;
  logic [SqW:0]        diff;

  assign cy   = (CoordW+2)'(ent_i.y);
  assign dx_d = (CoordW+1)'(px_q) - (CoordW+1)'(ent_i.x);
  assign dz_d = (CoordW+1)'(pz_q) - (CoordW+1)'(ent_i.z);

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      px_q  <= px_i;
      py_q  <= py_i;
      pz_q  <= pz_i;
      top_q <= (CoordW+2)'(py_i) + (CoordW+2)'({1'b0, above_i});
      bot_q <= (CoordW+2)'(py_i) - (CoordW+2)'({1'b0, below_i});
    end
    dx_q  <= dx_d;
    dz_q  <= dz_d;
    inw_q <= cmd_i.test && !(cy > top_q) && !(cy < bot_q);
    r_q   <= ent_i.r;
    a1_q  <= ent_i.area;
    p1_q  <= ent_i.prio;
    d2_q   <= D2W'(sx) + D2W'(sz);
    r2_q   <= r_q * r_q;
    inw2_q <= inw_q;
    a2_q   <= a1_q;
    p2_q   <= p1_q;
  end

  assign sx = (2*CoordW+2)'(dx_q * dx_q);
  assign sz = (2*CoordW+2)'(dz_q * dz_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (cmd_i.start) begin
      hit_q <= 1'b0;
    end else if (cmd_i.acc && inw2_q && ({4'b0, r2_q} >= d2_q)
                 && (!hit_q || p2_q > prio_q)) begin
      hit_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc && inw2_q && ({4'b0, r2_q} >= d2_q) && (!hit_q || p2_q > prio_q)) begin
      area_q <= a2_q;
      prio_q <= p2_q;
      bd2_q  <= d2_q;
      br2_q  <= r2_q;
    end
  end

  // ratio: restoring square root of d2 * 2^32 / r2, one result bit per cycle, msb first.
  // rem_q holds the partial remainder, mr_q the root so far times r2.
  assign pair   = (bit_q == 5'd16) ? bd2_q[1:0] : 2'b00;
  assign rem_sh = {rem_q[SqW-3:0], pair};
  assign trial  = {mr_q[SqW-3:0], 2'b00} + SqW'(br2_q);
  assign diff   = {1'b0, rem_sh} - {1'b0, trial};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q     <= '0;
      sq_done_q <= 1'b0;
      q_q       <= '0;
      rem_q     <= '0;
      mr_q      <= '0;
    end else if (cmd_i.sq_init) begin
      bit_q     <= 5'd16;
      sq_done_q <= (br2_q == '0) || !hit_q;
      q_q       <= '0;
      rem_q     <= SqW'(bd2_q >> 2);
      mr_q      <= '0;
    end else if (cmd_i.sq_step && !sq_done_q) begin
      if (!diff[SqW]) begin
        rem_q <= diff[SqW-1:0];
        mr_q  <= {mr_q[SqW-2:0], 1'b0} + SqW'(br2_q);
        q_q   <= {q_q[RatioW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        mr_q  <= {mr_q[SqW-2:0], 1'b0};
        q_q   <= {q_q[RatioW-2:0], 1'b0};
      end
      if (bit_q == '0) begin
        sq_done_q <= 1'b1;
      end else begin
        bit_q <= bit_q - 5'd1;
      end
    end
  end

  assign sts_o.sq_done = sq_done_q;
  assign hit_o   = hit_q;
  assign area_o  = hit_q ? area_q : '0;
  assign prio_o  = hit_q ? prio_q : '0;
  assign ratio_o = hit_q ? q_q : '0;
endmodule

// ----- src/pcal_ctrl.sv -----
// Controller: load writes, scan sequencing, ratio and result handshake.
module pcal_ctrl #(
  parameter int unsigned MaxCircles = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               op_i,
  input  logic [pcal_pkg::CountW-1:0]        count_i,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [$clog2(MaxCircles)-1:0]      raddr_o,
  output pcal_pkg::dp_cmd_t                  cmd_o,
  input  pcal_pkg::dp_sts_t                  sts_i
);
  import pcal_pkg::*;

  localparam int unsigned AW = $clog2(MaxCircles);
  localparam int unsigned NW = $clog2(MaxCircles + 1);
  localparam int unsigned CW = (NW > CountW) ? NW : CountW;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StScan = 3'd1;
  localparam logic [2:0] StSqrt = 3'd2;
  localparam logic [2:0] StOut  = 3'd3;
  localparam logic [2:0] StInit = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [NW-1:0] n_q, n_d, idx_q, idx_d;
  logic [2:0]    tv_q;  // test valid along read, stage 1, stage 2
  logic          issue;
  logic [CW-1:0] cnt_ext;

  assign cnt_ext = CW'(count_i);
  assign issue   = (state_q == StScan) && (idx_q < n_q);
  assign raddr_o = AW'(idx_q);
  assign in_ready  = (state_q == StIdle);
  assign out_valid = (state_q == StOut);

  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid && op_i == OpQuery) begin
          cmd_o.start = 1'b1;
          idx_d   = '0;
          n_d     = (cnt_ext > CW'(MaxCircles)) ? NW'(MaxCircles) : NW'(count_i);
          state_d = StScan;
        end
      end
      StScan: begin
        if (issue) idx_d = idx_q + NW'(1);
        if (!issue && tv_q == '0) state_d = StInit;
      end
      StInit: begin
        cmd_o.sq_init = 1'b1;
        state_d = StSqrt;
      end
      StSqrt: begin
        cmd_o.sq_step = 1'b1;
        if (sts_i.sq_done) state_d = StOut;
      end
      StOut: begin
        if (out_ready) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
    cmd_o.test = tv_q[0];
    cmd_o.acc  = tv_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      n_q     <= '0;
      idx_q   <= '0;
      tv_q    <= '0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      idx_q   <= idx_d;
      tv_q    <= {tv_q[1:0], issue};
    end
  end
endmodule

// ----- src/priority_circle_area_lookup_core.sv -----
// Top level of the priority circle area lookup.
// A load item writes one table entry, and loads can follow each other
// every cycle. A query item scans min(circle_count, MAX_CIRCLES) entries, one per
// cycle from a single RAM read port, then lets the test pipeline drain, then finds
// the ratio of the winner with a bit-serial square root of 17 steps (skipped when
// nothing hit or the radius is zero). The next item can be taken in the cycle
// after the result leaves. Entries must be loaded before a query scans them.
module priority_circle_area_lookup_core #(
  parameter int unsigned MAX_CIRCLES = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               op_i,
  input  logic [5:0]                         slot_i,
  input  logic signed [pcal_pkg::CoordW-1:0] pos_x_i,
  input  logic signed [pcal_pkg::CoordW-1:0] pos_y_i,
  input  logic signed [pcal_pkg::CoordW-1:0] pos_z_i,
  input  logic [pcal_pkg::RadW-1:0]          radius_i,
  input  logic [pcal_pkg::AreaW-1:0]         area_number_i,
  input  logic signed [pcal_pkg::PrioW-1:0]  area_priority_i,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               hit_o,
  output logic [pcal_pkg::AreaW-1:0]         hit_area_o,
  output logic signed [pcal_pkg::PrioW-1:0]  hit_priority_o,
  output logic [pcal_pkg::RatioW-1:0]        ratio_o,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic [pcal_pkg::HgtW-1:0]          cfg_data
);
  import pcal_pkg::*;

  localparam int unsigned AW = $clog2(MAX_CIRCLES);

  logic [CountW-1:0] count_q;
  logic [HgtW-1:0]   above_q, below_q;
  logic              we;
  logic [AW-1:0]     raddr;
  entry_t            wr_ent, rd_ent;
  dp_cmd_t           cmd;
  dp_sts_t           sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      above_q <= HgtW'(2400);
      below_q <= HgtW'(2400);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CfgCount: count_q <= cfg_data[CountW-1:0];
        CfgAbove: above_q <= cfg_data;
        CfgBelow: below_q <= cfg_data;
        default: ;
      endcase
    end
  end

  assign we = in_valid && in_ready && (op_i == OpLoad)
              && ({26'b0, slot_i} < 32'(MAX_CIRCLES));
  assign wr_ent = '{x: pos_x_i, y: pos_y_i, z: pos_z_i, r: radius_i,
                    area: area_number_i, prio: area_priority_i};

  pcal_ram #(.Width(EntryW), .Depth(MAX_CIRCLES)) u_ram (
    .clk_i, .we_i(we), .waddr_i(AW'(slot_i)), .wdata_i(wr_ent),
    .raddr_i(raddr), .rdata_o(rd_ent)
  );

  pcal_ctrl #(.MaxCircles(MAX_CIRCLES)) u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_ready, .op_i, .count_i(count_q),
    .out_valid, .out_ready, .raddr_o(raddr), .cmd_o(cmd), .sts_i(sts)
  );

  pcal_dp u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .ent_i(rd_ent),
    .px_i(pos_x_i), .py_i(pos_y_i), .pz_i(pos_z_i),
    .above_i(above_q), .below_i(below_q),
    .hit_o, .area_o(hit_area_o), .prio_o(hit_priority_o), .ratio_o
  );
endmodule

// ----- test/tb_top.sv -----
// Testbench for priority_circle_area_lookup_core: directed and random loads and queries.
`timescale 1ns / 100ps

module tb_top;
  import pcal_pkg::*;

  localparam int unsigned NumSlots = 64;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic op_i = OpLoad;
  logic [5:0] slot_i = '0;
  logic signed [CoordW-1:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic [RadW-1:0] radius_i = '0;
  logic [AreaW-1:0] area_number_i = '0;
  logic signed [PrioW-1:0] area_priority_i = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic hit_o;
  logic [AreaW-1:0] hit_area_o;
  logic signed [PrioW-1:0] hit_priority_o;
  logic [RatioW-1:0] ratio_o;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = CfgCount;
  logic [HgtW-1:0] cfg_data = '0;

  typedef struct packed {
    logic hit;
    logic [AreaW-1:0] area;
    logic signed [PrioW-1:0] prio;
    logic [RatioW-1:0] ratio;
  } answer_t;

  entry_t circles [NumSlots];
  logic [CountW-1:0] scan_count;
  logic [HgtW-1:0] win_above, win_below;
  answer_t answers_due [$];
  int mismatches = 0;
  int stall_left = 0;

  priority_circle_area_lookup_core u_dut (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // largest q <= 65536 with q*q*r2 <= d2 * 2^32
  function automatic logic [RatioW-1:0] ratio_of(logic [63:0] d2, logic [63:0] r2);
    logic [16:0] q;
    logic [16:0] c;
    logic [127:0] lhs, rhs;
    q = '0;
    if (r2 == 0) return '0;
    rhs = {64'd0, d2} << 32;
    for (int b = 16; b >= 0; b--) begin
      c = q | (17'd1 << b);
      if (c > 17'd65536) continue;
      lhs = 128'(c) * 128'(c) * 128'(r2);
      if (lhs <= rhs) q = c;
    end
    return q;
  endfunction

  function automatic answer_t lookup_point(logic signed [CoordW-1:0] px,
                                           logic signed [CoordW-1:0] py,
                                           logic signed [CoordW-1:0] pz);
    answer_t a;
    int n;
    longint top, bot, dx, dz;
    logic [63:0] d2, r2, bd2, br2;
    a = '0;
    bd2 = 0;
    br2 = 0;
    n = (scan_count > NumSlots) ? NumSlots : scan_count;
    top = longint'(py) + longint'(win_above);
    bot = longint'(py) - longint'(win_below);
    for (int i = 0; i < n; i++) begin
      if (longint'(circles[i].y) > top || longint'(circles[i].y) < bot) continue;
      dx = longint'(px) - longint'(circles[i].x);
      dz = longint'(pz) - longint'(circles[i].z);
      d2 = dx * dx + dz * dz;
      r2 = 64'(circles[i].r) * 64'(circles[i].r);
      if (d2 > r2) continue;
      if (a.hit && !(circles[i].prio > a.prio)) continue;
      a.hit = 1'b1;
      a.prio = circles[i].prio;
      a.area = circles[i].area;
      bd2 = d2;
      br2 = r2;
    end
    if (a.hit) a.ratio = ratio_of(bd2, br2);
    return a;
  endfunction

  // valid stays high after an accepted item only when the next one follows at once
  task automatic send_item(logic op, logic [5:0] slot, logic signed [CoordW-1:0] x,
                           logic signed [CoordW-1:0] y, logic signed [CoordW-1:0] z,
                           logic [RadW-1:0] r, logic [AreaW-1:0] area,
                           logic signed [PrioW-1:0] prio);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    op_i <= op;
    slot_i <= slot;
    pos_x_i <= x;
    pos_y_i <= y;
    pos_z_i <= z;
    radius_i <= r;
    area_number_i <= area;
    area_priority_i <= prio;
    do @(posedge clk_i); while (!in_ready);
    if (op == OpLoad) begin
      circles[slot] = '{x: x, y: y, z: z, r: r, area: area, prio: prio};
    end else begin
      answers_due.push_back(lookup_point(x, y, z));
    end
  endtask

  task automatic load_entry(int s, logic signed [CoordW-1:0] x, logic signed [CoordW-1:0] y,
                            logic signed [CoordW-1:0] z, logic [RadW-1:0] r,
                            logic [AreaW-1:0] a, logic signed [PrioW-1:0] p);
    send_item(OpLoad, 6'(s), x, y, z, r, a, p);
  endtask

  task automatic query_point(logic signed [CoordW-1:0] x, logic signed [CoordW-1:0] y,
                             logic signed [CoordW-1:0] z);
    send_item(OpQuery, 6'($urandom), x, y, z, 23'($urandom), 12'($urandom), 16'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [HgtW-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CfgCount: scan_count = CountW'(val);
      CfgAbove: win_above = val;
      CfgBelow: win_below = val;
      default: ;
    endcase
  endtask

  task automatic load_random(int s, int spread);
    load_entry(s, 24'($signed($urandom_range(0, 2 * spread)) - spread),
               24'($signed($urandom_range(0, 2 * spread)) - spread),
               24'($signed($urandom_range(0, 2 * spread)) - spread),
               23'($urandom_range(0, spread)), 12'($urandom), 16'($urandom));
  endtask

  task automatic test_directed();
    load_entry(0, 0, 0, 0, 100, 12'd7, 16'sd5);
    load_entry(1, 0, 0, 0, 200, 12'd9, 16'sd5);
    load_entry(2, 60, 0, 80, 100, 12'hFFF, 16'sh7FFF);
    load_entry(3, 10, 0, 0, 0, 12'd3, -16'sd32768);
    load_entry(4, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 23'h7FFFFF, 12'd1, 16'sd9);
    load_entry(63, 24'sh800000, 24'sh800000, 24'sh7FFFFF, 23'h7FFFFF, 12'd2, 16'sd1);
    query_point(0, 0, 0);
    write_reg(CfgCount, 1);
    query_point(0, 0, 0);
    query_point(60, 0, 0);
    query_point(101, 0, 0);
    write_reg(CfgCount, 3);
    query_point(150, 0, 0);
    query_point(60, 0, 80);
    write_reg(CfgCount, 4);
    query_point(10, 0, 0);
    write_reg(CfgCount, 5);
    query_point(24'sh800000, 24'sh800000, 24'sh7FFFFF);
    query_point(24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000);
    write_reg(CfgAbove, 0);
    write_reg(CfgBelow, 0);
    query_point(0, 0, 0);
    query_point(0, 1, 0);
    write_reg(CfgAbove, 23'h7FFFFF);
    write_reg(CfgBelow, 23'h7FFFFF);
    query_point(0, 24'sh800000, 0);
    query_point(0, 24'sh7FFFFF, 0);
    load_entry(6'h3F, 1, 1, 1, 1, 12'd0, 16'sd0);
  endtask

  task automatic test_random_tables(int queries);
    for (int s = 0; s < NumSlots; s++) load_random(s, 4000);
    for (int k = 0; k < queries; k++) begin
      if (k % 150 == 0) begin
        write_reg(CfgCount,
                  HgtW'($urandom_range(0, 100) < 15 ? 127 : $urandom_range(0, 64)));
        write_reg(CfgAbove,
                  $urandom_range(0, 100) < 10 ? 23'h7FFFFF : HgtW'($urandom_range(0, 6000)));
        write_reg(CfgBelow,
                  $urandom_range(0, 100) < 10 ? 23'h7FFFFF : HgtW'($urandom_range(0, 6000)));
      end
      if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 9) == 0)
          load_entry($urandom_range(0, 63), 24'($urandom), 24'($urandom), 24'($urandom),
                     23'($urandom), 12'($urandom), 16'($urandom));
        else
          load_random($urandom_range(0, 63), 4000);
      end else if ($urandom_range(0, 19) == 0) begin
        query_point(24'($urandom), 24'($urandom), 24'($urandom));
      end else begin
        query_point(24'($signed($urandom_range(0, 8000)) - 4000),
                    24'($signed($urandom_range(0, 8000)) - 4000),
                    24'($signed($urandom_range(0, 8000)) - 4000));
      end
    end
  endtask

  // lower priorities in a small area so ties and overlaps are common
  task automatic test_crowded(int queries);
    write_reg(CfgCount, 64);
    for (int s = 0; s < NumSlots; s++)
      load_entry(s, 24'($signed($urandom_range(0, 400)) - 200), 24'($urandom_range(0, 50)),
                 24'($signed($urandom_range(0, 400)) - 200), 23'($urandom_range(0, 300)),
                 12'($urandom), 16'($signed($urandom_range(0, 6)) - 3));
    for (int k = 0; k < queries; k++)
      query_point(24'($signed($urandom_range(0, 600)) - 300), 24'($urandom_range(0, 50)),
                  24'($signed($urandom_range(0, 600)) - 300));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        if (answers_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item");
        end else begin
          answer_t e;
          e = answers_due.pop_front();
          if (hit_o !== e.hit || hit_area_o !== e.area || hit_priority_o !== e.prio ||
              ratio_o !== e.ratio) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp hit %0d area %0d prio %0d ratio %0d, got %0d %0d %0d %0d",
                       e.hit, e.area, e.prio, e.ratio,
                       hit_o, hit_area_o, hit_priority_o, ratio_o);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 3) begin
        stall_left = $urandom_range(4, 30);
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) < 8) ? 1'b0 : ($urandom_range(0, 99) < 75);
      end
    end
  end

  initial begin
    scan_count = '0;
    win_above = 23'd2400;
    win_below = 23'd2400;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_tables(900);
    test_crowded(160);
    drain();
    if (mismatches == 0 && answers_due.size() == 0)
      $display("priority_circle_area_lookup_core test passed");
    else
      $display("priority_circle_area_lookup_core test failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("priority_circle_area_lookup_core test failed");
    $finish;
  end

endmodule
